@@ hw/rtl/gf16_multiply_accumulate_column_top_macros.svh @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef GF16_MULTIPLY_ACCUMULATE_COLUMN_TOP_MACROS_SVH
`define GF16_MULTIPLY_ACCUMULATE_COLUMN_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must never hold
`define GF16MAC_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("never-condition violated");

// ante implies cons in the same cycle
`define GF16MAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// ante implies cons in the next cycle
`define GF16MAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define GF16MAC_ASSERT_NEVER(label, clk, rst_n, cond)
`define GF16MAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GF16MAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/gf16mac_pkg.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column package
// Item types, action codes and the carry-less multiply and reduction
// functions shared by the column's front end and execution unit.
// ----------------------------------------------------------------------------
package gf16mac_pkg;

	localparam int unsigned ColumnDepthDefault = 1024;
	localparam int unsigned IndexW = 10;
	localparam int unsigned HalfW = 16;
	localparam int unsigned AccW = 31;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

	// action field codes
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_MAC = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_READ
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [IndexW-1:0] entry_index;
		logic [HalfW-1:0] coefficient;
		logic [HalfW-1:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [HalfW-1:0] reduced_value;
		logic [IndexW-1:0] result_index;
	} out_item_t;

	// classified work passed from front end to execution unit
	typedef struct packed {
		op_t op;
		logic in_range;
		logic [IndexW-1:0] idx;
		logic [AccW-1:0] operand;
	} work_t;

	function automatic logic [AccW-1:0] clmul16(logic [HalfW-1:0] a, logic [HalfW-1:0] b);
		logic [AccW-1:0] p;
		p = '0;
		for (int i = 0; i < HalfW; i++) begin
			if (b[i]) begin
				p = p ^ (AccW'(a) << i);
			end
		end
		return p;
	endfunction

	// multiply by x^5 + x^3 + x + 1
	function automatic logic [19:0] times_low(logic [14:0] v);
		return {5'b0, v} ^ {4'b0, v, 1'b0} ^ {2'b0, v, 3'b0} ^ {v, 5'b0};
	endfunction

	// two folds of the upper half modulo x^16 + x^5 + x^3 + x + 1
	function automatic logic [HalfW-1:0] reduce(logic [AccW-1:0] acc);
		logic [19:0] f1;
		logic [19:0] f2;
		f1 = times_low(acc[30:16]);
		f2 = times_low({11'b0, f1[19:16]});
		return acc[15:0] ^ f1[15:0] ^ {7'b0, f2[8:0]};
	endfunction

endpackage

@@ hw/rtl/gf16_multiply_accumulate_column_top.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) multiply-accumulate column
// Column of 31-bit unreduced accumulators with load, carry-less
// multiply-accumulate and reduced read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise push; the item transfers on a rising
//   edge with push high and full low. Load (action 0) and multiply-accumulate
//   (action 1) produce no result; read (action 2) produces one result.
//   Output channel: while empty is low, result holds the oldest reduced read;
//   it transfers on a rising edge with pop high and empty low.
//   Pacing: the execution unit takes a new item only after it has finished
//   the last one, set by its read-modify-write of the single-port
//   accumulator memory (read as the item is taken, then write or reduce in
//   the execute state), and only while the result register is empty or
//   being popped. A two-entry queue and one front register absorb short
//   stalls.
//   Reset: clears the front register, queue and result register; accumulator
//   contents are not cleared and must be loaded before they are read.
//   Receiver stall: the result register holds its value, the execution unit
//   stops taking work, the queue fills and full rises.
// ----------------------------------------------------------------------------
module gf16_multiply_accumulate_column_top #(
	parameter int unsigned COLUMN_DEPTH = gf16mac_pkg::ColumnDepthDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  gf16mac_pkg::in_item_t  item,
	output logic                   empty,
	input  logic                   pop,
	output gf16mac_pkg::out_item_t result
);
	import gf16mac_pkg::*;

	logic fq_push;
	logic fq_full;
	work_t fq_data;
	logic bq_pop;
	logic bq_empty;
	work_t bq_data;

	gf16mac_front #(
		.COLUMN_DEPTH(COLUMN_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (fq_push),
		.q_full (fq_full),
		.q_data (fq_data)
	);

	gf16mac_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_data),
		.q_full  (fq_full),
		.rd_en   (bq_pop),
		.rd_data (bq_data),
		.q_empty (bq_empty)
	);

	gf16mac_back #(
		.COLUMN_DEPTH(COLUMN_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (bq_empty),
		.q_data  (bq_data),
		.q_pop   (bq_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

@@ hw/rtl/gf16mac_front.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column front end
// Accepts items, drops ones that change nothing, forms the carry-less
// product and hands classified work to the queue.
// ----------------------------------------------------------------------------
module gf16mac_front #(
	parameter int unsigned COLUMN_DEPTH = gf16mac_pkg::ColumnDepthDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  gf16mac_pkg::in_item_t  item,
	output logic                   q_push,
	input  logic                   q_full,
	output gf16mac_pkg::work_t     q_data
);
	import gf16mac_pkg::*;

	logic valid_s1;
	work_t work_s1;
	work_t work_d;
	logic keep;
	logic accept;
	logic in_range;

	assign in_range = 32'(item.entry_index) < COLUMN_DEPTH;
	assign full = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_data = work_s1;

	always_comb begin
		work_d.idx = item.entry_index;
		work_d.in_range = in_range;
		work_d.op = OP_READ;
		work_d.operand = '0;
		keep = 1'b0;
		case (item.action)
			ACT_LOAD: begin
				work_d.op = OP_LOAD;
				work_d.operand = AccW'(item.data_word);
				keep = in_range;
			end
			ACT_MAC: begin
				work_d.op = OP_MAC;
				work_d.operand = clmul16(item.coefficient, item.data_word);
				keep = in_range;
			end
			ACT_READ: begin
				work_d.op = OP_READ;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= work_d;
		end
	end

endmodule

@@ hw/rtl/gf16mac_queue.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column work queue
// Short first-in first-out buffer between the front end and the
// execution unit.
// ----------------------------------------------------------------------------
module gf16mac_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  gf16mac_pkg::work_t  wr_data,
	output logic                q_full,
	input  logic                rd_en,
	output gf16mac_pkg::work_t  rd_data,
	output logic                q_empty
);
	import gf16mac_pkg::*;

	work_t slots_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign q_full = count_q == QueueCntW'(QueueDepth);
	assign q_empty = count_q == '0;
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = slots_q[rd_ptr_q];

	function automatic logic [QueuePtrW-1:0] advance(logic [QueuePtrW-1:0] p);
		return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ hw/rtl/gf16mac_back.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column execution unit
// Holds the accumulator memory, performs read-modify-write for loads and
// multiply-accumulates and reduces entries into the result register on reads.
// ----------------------------------------------------------------------------
`include "gf16_multiply_accumulate_column_top_macros.svh"

module gf16mac_back #(
	parameter int unsigned COLUMN_DEPTH = gf16mac_pkg::ColumnDepthDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  gf16mac_pkg::work_t     q_data,
	output logic                   q_pop,
	output logic                   empty,
	input  logic                   pop,
	output gf16mac_pkg::out_item_t result
);
	import gf16mac_pkg::*;

	localparam int unsigned AddrW = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;

	logic [AccW-1:0] acc_mem [COLUMN_DEPTH];

	back_state_t state_q;
	back_state_t state_d;
	work_t cur_q;
	logic [AccW-1:0] rdata_q;
	logic out_valid_q;
	out_item_t out_q;

	logic slot_free;
	logic mem_we;
	logic res_load;
	logic [AccW-1:0] wdata;
	logic [HalfW-1:0] red_value;

	assign slot_free = !out_valid_q || pop;
	assign empty = !out_valid_q;
	assign result = out_q;
	assign red_value = cur_q.in_range ? reduce(rdata_q) : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && slot_free) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		mem_we = 1'b0;
		res_load = 1'b0;
		wdata = rdata_q ^ cur_q.operand;
		case (state_q)
			BK_IDLE: begin
				// take the next item only when its result has somewhere to go
				q_pop = !q_empty && slot_free;
			end
			BK_EXEC: begin
				case (cur_q.op)
					OP_LOAD: begin
						mem_we = 1'b1;
						wdata = cur_q.operand;
					end
					OP_MAC: begin
						mem_we = 1'b1;
					end
					OP_READ: begin
						res_load = 1'b1;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (res_load) begin
			out_q.reduced_value <= red_value;
			out_q.result_index <= cur_q.idx;
		end
	end

	// single-port column: read on pop, write back in the execute cycle
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdata_q <= acc_mem[AddrW'(q_data.idx)];
		end
		if (mem_we) begin
			acc_mem[AddrW'(cur_q.idx)] <= wdata;
		end
	end

	`GF16MAC_ASSERT_NEXT(a_exec_one_cycle, clk, arst_n, state_q == BK_EXEC, state_q == BK_IDLE)
	`GF16MAC_ASSERT_IMPLIES(a_read_slot_free, clk, arst_n, res_load, !out_valid_q)
	`GF16MAC_ASSERT_NEVER(a_pop_outside_idle, clk, arst_n, q_pop && state_q != BK_IDLE)
	`GF16MAC_ASSERT_NEXT(a_fill_only_by_read, clk, arst_n, !out_valid_q && !res_load, !out_valid_q)

endmodule

@@ sim/gf16_mac_column_check.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column result check
// Watches both queue ports of the column, keeps its own copy of the
// accumulators, works out the reduced value of every read and compares it
// field by field with the results that leave the block, oldest first.
// ----------------------------------------------------------------------------
module gf16_mac_column_check (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   full,
	input  gf16mac_pkg::in_item_t  item,
	input  logic                   empty,
	input  logic                   pop,
	input  gf16mac_pkg::out_item_t result,
	output int unsigned            failures,
	output int unsigned            pending
);
	import gf16mac_pkg::*;

	localparam int unsigned Depth = ColumnDepthDefault;

	logic [AccW-1:0] column_acc [Depth];
	out_item_t reads_due [$];

	// multiply by x^5 + x^3 + x + 1, the tail of the field polynomial
	function automatic logic [19:0] times_tail(logic [19:0] v);
		return v ^ (v << 1) ^ (v << 3) ^ (v << 5);
	endfunction

	always @(posedge clk) begin
		logic [AccW-1:0] product;
		logic [AccW-1:0] acc;
		logic [19:0] upper_fold;
		logic [19:0] spill_fold;
		out_item_t due;
		out_item_t got;

		if (arst_n) begin
			if (push && !full) begin
				case (item.action)
					ACT_LOAD: begin
						if (item.entry_index < Depth)
							column_acc[item.entry_index] = AccW'(item.data_word);
					end
					ACT_MAC: begin
						product = '0;
						for (int b = 0; b < HalfW; b++)
							if (item.data_word[b])
								product = product ^ (AccW'(item.coefficient) << b);
						if (item.entry_index < Depth)
							column_acc[item.entry_index] = column_acc[item.entry_index] ^ product;
					end
					ACT_READ: begin
						due.result_index = item.entry_index;
						due.reduced_value = '0;
						if (item.entry_index < Depth) begin
							acc = column_acc[item.entry_index];
							// fold the upper half twice
							upper_fold = times_tail(20'(acc[30:16]));
							spill_fold = times_tail(20'(upper_fold[19:16]));
							due.reduced_value = acc[15:0] ^ upper_fold[15:0] ^ spill_fold[15:0];
						end
						reads_due.push_back(due);
					end
					default: begin
						// unused action: no effect, no result
					end
				endcase
			end

			if (pop && !empty) begin
				got = result;
				if (reads_due.size() == 0) begin
					$error("unexpected result: result_index %0d reduced_value 0x%04h",
						got.result_index, got.reduced_value);
					failures++;
				end else begin
					due = reads_due.pop_front();
					if (got.reduced_value !== due.reduced_value) begin
						$error("reduced_value: expected 0x%04h, actual 0x%04h",
							due.reduced_value, got.reduced_value);
						failures++;
					end
					if (got.result_index !== due.result_index) begin
						$error("result_index: expected %0d, actual %0d",
							due.result_index, got.result_index);
						failures++;
					end
				end
			end
		end
		pending <= reads_due.size();
	end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) MAC column testbench
// Drives loads, multiply-accumulates, reads and the unused action into the
// column with random gaps on both queue ports, one long receiver hold-off and
// two full drains; a separate check module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import gf16mac_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned HoldCycles = 200;
	localparam int unsigned BlockCount = 13;
	localparam int unsigned BlockItems = 50;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t item;
	logic empty;
	logic pop;
	out_item_t result;

	int unsigned failures;
	int unsigned pending;

	bit written_entry [ColumnDepthDefault];
	int unsigned written_list [$];

	bit hold_wanted;
	bit hold_active;

	gf16_multiply_accumulate_column_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	gf16_mac_column_check column_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.failures(failures),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// half the time hit a few entries at both ends so accesses collide
	function automatic logic [IndexW-1:0] pick_index();
		if ($urandom_range(0, 1))
			return IndexW'($urandom_range(0, 1) ? $urandom_range(0, 7)
				: $urandom_range(1016, 1023));
		return IndexW'($urandom_range(0, 1023));
	endfunction

	function automatic logic [HalfW-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return HalfW'(1) << $urandom_range(0, 15);
			default: return HalfW'($urandom);
		endcase
	endfunction

	task automatic send_op(logic [1:0] act, logic [IndexW-1:0] idx,
		logic [HalfW-1:0] coef, logic [HalfW-1:0] data);
		in_item_t it;
		it.action = act;
		it.entry_index = idx;
		it.coefficient = coef;
		it.data_word = data;
		if (act == ACT_LOAD && !written_entry[idx]) begin
			written_entry[idx] = 1'b1;
			written_list.push_back(32'(idx));
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
	endtask

	task automatic sender_idle(int unsigned cycles);
		if (cycles > 0) begin
			push <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// drop push and hold until every read has returned
	task automatic sender_drain();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// reads go only to entries that have been loaded
	task automatic send_random();
		int unsigned roll;
		logic [IndexW-1:0] idx;
		roll = $urandom_range(0, 99);
		if (written_list.size() == 0 || roll < 20) begin
			send_op(ACT_LOAD, pick_index(), HalfW'($urandom), pick_word());
		end else if (roll < 60) begin
			if ($urandom_range(0, 3) != 0)
				idx = IndexW'(written_list[$urandom_range(0, written_list.size() - 1)]);
			else
				idx = pick_index();
			send_op(ACT_MAC, idx, pick_word(), pick_word());
		end else if (roll < 95) begin
			idx = IndexW'(written_list[$urandom_range(0, written_list.size() - 1)]);
			send_op(ACT_READ, idx, HalfW'($urandom), HalfW'($urandom));
		end else begin
			send_op(ACT_UNUSED, IndexW'($urandom), HalfW'($urandom), HalfW'($urandom));
		end
	endtask

	// receiver: random pop gaps and bursts, one long hold-off on request
	initial begin
		int unsigned gap;
		pop <= 1'b0;
		hold_wanted = 1'b0;
		hold_active = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_active = 1'b1;
				pop <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_active = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				pop <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		#5000000;
		$display("gf16_multiply_accumulate_column_top test failed");
		$finish;
	end

	initial begin
		bit steady;
		arst_n = 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, cancellation, back-to-back hazards, unused action
		send_op(ACT_LOAD, 10'd0, 16'h0000, 16'h0000);      sender_idle(pick_gap());
		send_op(ACT_READ, 10'd0, 16'h0000, 16'h0000);      sender_idle(pick_gap());
		send_op(ACT_LOAD, 10'd1023, 16'hFFFF, 16'hFFFF);   sender_idle(pick_gap());
		send_op(ACT_READ, 10'd1023, 16'hFFFF, 16'hFFFF);   sender_idle(pick_gap());
		send_op(ACT_MAC, 10'd1023, 16'hFFFF, 16'hFFFF);    sender_idle(pick_gap());
		send_op(ACT_READ, 10'd1023, 16'h0000, 16'h0000);   sender_idle(pick_gap());
		send_op(ACT_MAC, 10'd1023, 16'hFFFF, 16'hFFFF);
		send_op(ACT_READ, 10'd1023, 16'h0000, 16'h0000);   sender_idle(pick_gap());
		send_op(ACT_LOAD, 10'd5, 16'h0000, 16'h8000);
		send_op(ACT_MAC, 10'd5, 16'h8000, 16'h8000);
		send_op(ACT_MAC, 10'd5, 16'h0000, 16'hFFFF);
		send_op(ACT_READ, 10'd5, 16'h0000, 16'h0000);
		send_op(ACT_MAC, 10'd5, 16'h0001, 16'h1234);
		send_op(ACT_MAC, 10'd5, 16'hABCD, 16'hFFFF);
		send_op(ACT_READ, 10'd5, 16'h0000, 16'h0000);      sender_idle(pick_gap());
		send_op(ACT_UNUSED, 10'd0, 16'hFFFF, 16'hFFFF);
		send_op(ACT_READ, 10'd0, 16'h0000, 16'h0000);
		send_op(ACT_LOAD, 10'd0, 16'h0000, 16'hFFFF);
		send_op(ACT_READ, 10'd0, 16'h0000, 16'h0000);      sender_idle(pick_gap());
		send_op(ACT_LOAD, 10'd512, 16'h0000, 16'h002B);
		send_op(ACT_MAC, 10'd512, 16'h00FF, 16'hFF00);
		send_op(ACT_READ, 10'd512, 16'h0000, 16'h0000);    sender_idle(pick_gap());

		for (int unsigned blk = 0; blk < BlockCount; blk++) begin
			steady = ($urandom_range(0, 3) == 0);
			if (blk == 4) begin
				// stall the receiver and keep offering items until full rises
				push <= 1'b0;
				hold_wanted = 1'b1;
				wait (hold_active);
				@(posedge clk);
				steady = 1'b1;
			end
			if (blk == 8)
				sender_drain();
			for (int unsigned n = 0; n < BlockItems; n++) begin
				send_random();
				if (!steady)
					sender_idle(pick_gap());
			end
		end

		sender_drain();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("gf16_multiply_accumulate_column_top test passed");
		else
			$display("gf16_multiply_accumulate_column_top test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gf16mac_pkg.sv
hw/rtl/gf16mac_front.sv
hw/rtl/gf16mac_queue.sv
hw/rtl/gf16mac_back.sv
hw/rtl/gf16_multiply_accumulate_column_top.sv
sim/gf16_mac_column_check.sv
sim/testbench.sv
